### sv/assert_macros.svh
// Assertion macros for the RTL.
// No dependencies; taken in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

### sv/prr_pkg.sv
// Types and constants of the polynomial ray reconstruction unit.
// No dependencies.
`default_nettype none
package prr_pkg;

	localparam int MAX_TERMS_DEF = 256;
	localparam int CNT_W = 9;
	// cm to metres: q = floor((8192*|raw| + 25) / 50) = round(|raw| * 2^14 / 100),
	// taken as round(n * CM2M_RECIP / 2^30) >> CM2M_SHIFT; CM2M_RECIP = ceil(2^51 / 50)
	localparam logic [63:0] CM2M_RECIP = 64'd45035996273705;
	localparam int CM2M_SHIFT = 21;

	typedef struct packed {
		logic action;
		logic [7:0] term_index;
		logic signed [47:0] coef_xptar;
		logic signed [47:0] coef_ytar;
		logic signed [47:0] coef_yptar;
		logic signed [47:0] coef_delta;
		logic [19:0] exponent_digits;
		logic signed [31:0] focal_x_cm;
		logic signed [31:0] focal_dx;
		logic signed [31:0] focal_y_cm;
		logic signed [31:0] focal_dy;
	} cmd_t;

	typedef struct packed {
		logic signed [47:0] xptar;
		logic signed [47:0] ytar_cm;
		logic signed [47:0] yptar;
		logic signed [47:0] delta_pct;
		logic status;
	} res_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mul_stat_t;

endpackage
`default_nettype wire

### sv/prr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module prr_ram #(
	parameter int W = 48,
	parameter int D = 1024,
	parameter int AW = (D > 1) ? $clog2(D) : 1
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [W-1:0] wdata,
	input wire logic [AW-1:0] raddr,
	output logic [W-1:0] rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### sv/prr_mul.sv
// Shared fixed-point multiplier: round(a*b / 2^30) with saturation.
// 64x64 magnitude product from four 32x32 partials; uses prr_pkg.
`default_nettype none
module prr_mul
	import prr_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic go,
	input wire logic signed [63:0] a,
	input wire logic signed [63:0] b,
	input wire logic lim63,
	output mul_stat_t stat,
	output logic signed [63:0] y
);
	logic [63:0] ua_q, ub_q;
	logic neg_q, lim_q;
	logic [2:0] c_q;
	logic run_q, pv_q, fin_q, done_q;
	logic [63:0] prod_q;
	logic [6:0] sh_q;
	logic [127:0] acc_q;
	logic [31:0] pa, pb;
	logic [6:0] sh_n;
	logic [127:0] rsum;
	logic [63:0] q;
	logic sat;
	logic signed [63:0] y_n;

	always_comb begin
		pa = c_q[1] ? ua_q[63:32] : ua_q[31:0];
		pb = c_q[0] ? ub_q[63:32] : ub_q[31:0];
		case (c_q[1:0])
			2'd0: sh_n = 7'd0;
			2'd3: sh_n = 7'd64;
			default: sh_n = 7'd32;
		endcase
		rsum = acc_q + 128'h2000_0000;
		q = rsum[93:30];
		sat = (|rsum[127:94]) | (lim_q ? q[63] : (|q[63:62]));
		if (sat) begin
			if (lim_q) begin
				y_n = neg_q ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
			end else begin
				y_n = neg_q ? 64'shC000_0000_0000_0000 : 64'sh3FFF_FFFF_FFFF_FFFF;
			end
		end else begin
			y_n = neg_q ? -$signed(q) : $signed(q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			pv_q <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
			c_q <= '0;
		end else begin
			done_q <= 1'b0;
			fin_q <= 1'b0;
			if (go) begin
				ua_q <= a[63] ? (~a + 64'd1) : a;
				ub_q <= b[63] ? (~b + 64'd1) : b;
				neg_q <= a[63] ^ b[63];
				lim_q <= lim63;
				acc_q <= '0;
				c_q <= '0;
				run_q <= 1'b1;
				pv_q <= 1'b0;
			end else if (run_q) begin
				if (c_q != 3'd4) begin
					prod_q <= pa * pb;
					sh_q <= sh_n;
					pv_q <= 1'b1;
					c_q <= c_q + 3'd1;
				end else begin
					pv_q <= 1'b0;
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
				if (pv_q) begin
					acc_q <= acc_q + ({64'd0, prod_q} << sh_q);
				end
			end
			if (fin_q) begin
				y <= y_n;
				done_q <= 1'b1;
			end
		end
	end

	assign stat.busy = run_q | pv_q | fin_q;
	assign stat.done = done_q;
endmodule
`default_nettype wire

### sv/polynomial_ray_reconstruction_unit.sv
// Polynomial ray reconstruction unit: one word in flight at a time, busy while working.
// Load writes one term's four coefficients and exponents; reconstruct with zero
// terms strobes zeros with status set, else runs two cm-to-m reciprocal multiplies,
// then per term the powers and four coefficient products, all on the one shared
// 4-pass multiplier. Results strobe one cycle, never stalled; next word
// is taken at the edge that ends the strobe. arst_n clears control state and term_count.
`default_nettype none
`include "assert_macros.svh"
module polynomial_ray_reconstruction_unit
	import prr_pkg::*;
#(
	parameter int MAX_TERMS = MAX_TERMS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire cmd_t cmd,
	output res_t result,
	output logic result_valid,
	input wire logic cfg_we,
	input wire logic [CNT_W-1:0] cfg_wdata
);
	localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

	typedef enum logic [3:0] {
		S_IDLE, S_LWR, S_DLD, S_DRUN, S_DEND, S_TRD, S_TEXP, S_PCHK,
		S_PGO, S_PWAIT, S_CRD, S_CGO, S_CWAIT, S_NXT, S_FIN1, S_FIN2
	} state_t;

	state_t state_q;
	cmd_t in_q;
	logic ld_ok_q;
	logic [CNT_W-1:0] term_count_q, last_q, t_q;
	logic [1:0] j_q, v_q;
	logic dsel_q;
	logic [15:0] ex_q;
	logic signed [63:0] mono_q;
	logic signed [63:0] var_q [4];
	logic signed [63:0] acc_q [4];
	logic signed [47:0] s48_q [4];

	// table ports
	logic coef_we, exp_we;
	logic [AW+1:0] coef_waddr, coef_raddr;
	logic [AW-1:0] exp_waddr, exp_raddr;
	logic [47:0] coef_wdata, coef_rdata;
	logic [19:0] exp_rdata;

	// shared multiplier
	logic mul_go, mul_lim;
	logic signed [63:0] mul_b, mul_y;
	mul_stat_t mul_stat;

	// conversion operand and count clamp
	logic [31:0] dmag;
	logic signed [31:0] dsrc;
	logic signed [63:0] cvt;
	logic [CNT_W-1:0] n_eff;

	function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
			logic signed [63:0] b);
		logic signed [63:0] s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63]) begin
			return a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
		end
		return s;
	endfunction

	function automatic logic signed [47:0] sat48(logic signed [63:0] v);
		if (v[63:47] != {17{v[63]}}) begin
			return v[63] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
		end
		return v[47:0];
	endfunction

	// scale to cm / percent: x*100 as shifts and adds
	function automatic logic signed [47:0] times100(logic signed [47:0] x);
		logic signed [63:0] w;
		w = 64'(x);
		return sat48((w <<< 6) + (w <<< 5) + (w <<< 2));
	endfunction

	always_comb begin
		n_eff = (32'(term_count_q) > MAX_TERMS) ? CNT_W'(MAX_TERMS) : term_count_q;
		dsrc = dsel_q ? in_q.focal_y_cm : in_q.focal_x_cm;
		dmag = dsrc[31] ? (~dsrc + 32'd1) : dsrc;
		// metres magnitude from the reciprocal product
		cvt = mul_y >>> CM2M_SHIFT;
		mul_go = (state_q == S_PGO) || (state_q == S_CGO) || (state_q == S_DRUN);
		mul_lim = (state_q == S_CGO);
		if (state_q == S_DRUN) begin
			mul_b = $signed(CM2M_RECIP);
		end else if (state_q == S_CGO) begin
			mul_b = 64'(signed'(coef_rdata));
		end else begin
			mul_b = var_q[v_q];
		end
		coef_we = (state_q == S_LWR) && ld_ok_q;
		exp_we = (state_q == S_LWR) && ld_ok_q && (j_q == 2'd0);
		coef_waddr = {AW'(in_q.term_index), j_q};
		exp_waddr = AW'(in_q.term_index);
		coef_raddr = {AW'(t_q), j_q};
		exp_raddr = AW'(t_q);
		case (j_q)
			2'd0: coef_wdata = in_q.coef_xptar;
			2'd1: coef_wdata = in_q.coef_ytar;
			2'd2: coef_wdata = in_q.coef_yptar;
			default: coef_wdata = in_q.coef_delta;
		endcase
	end

	prr_ram #(.W(48), .D(4 * MAX_TERMS), .AW(AW + 2)) u_coef_ram (
		.clk(clk), .we(coef_we), .waddr(coef_waddr), .wdata(coef_wdata),
		.raddr(coef_raddr), .rdata(coef_rdata)
	);

	prr_ram #(.W(20), .D(MAX_TERMS), .AW(AW)) u_exp_ram (
		.clk(clk), .we(exp_we), .waddr(exp_waddr), .wdata(in_q.exponent_digits),
		.raddr(exp_raddr), .rdata(exp_rdata)
	);

	prr_mul u_mul (
		.clk(clk), .arst_n(arst_n), .go(mul_go), .a(mono_q), .b(mul_b),
		.lim63(mul_lim), .stat(mul_stat), .y(mul_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			term_count_q <= '0;
			result_valid <= 1'b0;
			j_q <= '0;
			t_q <= '0;
		end else begin
			result_valid <= 1'b0;
			if (cfg_we) begin
				term_count_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						in_q <= cmd;
						ld_ok_q <= 32'(cmd.term_index) < MAX_TERMS;
						var_q[1] <= 64'(cmd.focal_dx);
						var_q[3] <= 64'(cmd.focal_dy);
						j_q <= '0;
						dsel_q <= 1'b0;
						last_q <= n_eff - CNT_W'(1);
						if (!cmd.action) begin
							state_q <= S_LWR;
						end else if (n_eff == '0) begin
							// empty table: zeros, status set
							result <= '{xptar: '0, ytar_cm: '0, yptar: '0,
								delta_pct: '0, status: 1'b1};
							result_valid <= 1'b1;
						end else begin
							state_q <= S_DLD;
						end
					end
				end
				S_LWR: begin
					// one coefficient per cycle, exponents with the first
					j_q <= j_q + 2'd1;
					if (j_q == 2'd3) begin
						result <= '0;
						result_valid <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DLD: begin
					// metres in Q.14 = round(cm_raw * 2^14 / 100) = floor((8192|raw| + 25) / 50)
					mono_q <= $signed(64'({dmag, 13'd0}) + 64'd25);
					state_q <= S_DRUN;
				end
				S_DRUN: begin
					state_q <= S_DEND;
				end
				S_DEND: begin
					if (mul_stat.done) begin
						if (dsel_q) begin
							var_q[2] <= dsrc[31] ? -cvt : cvt;
							t_q <= '0;
							for (int i = 0; i < 4; i++) begin
								acc_q[i] <= '0;
							end
							state_q <= S_TRD;
						end else begin
							var_q[0] <= dsrc[31] ? -cvt : cvt;
							dsel_q <= 1'b1;
							state_q <= S_DLD;
						end
					end
				end
				S_TRD: begin
					state_q <= S_TEXP;
				end
				S_TEXP: begin
					ex_q <= exp_rdata[19:4];
					mono_q <= 64'sd1 <<< 30;
					v_q <= '0;
					// a term on the fifth variable adds nothing
					state_q <= (exp_rdata[3:0] != 4'd0) ? S_NXT : S_PCHK;
				end
				S_PCHK: begin
					if (ex_q[15:12] != 4'd0) begin
						state_q <= S_PGO;
					end else if (v_q == 2'd3) begin
						j_q <= '0;
						state_q <= S_CRD;
					end else begin
						v_q <= v_q + 2'd1;
						ex_q <= {ex_q[11:0], 4'd0};
					end
				end
				S_PGO: begin
					state_q <= S_PWAIT;
				end
				S_PWAIT: begin
					if (mul_stat.done) begin
						mono_q <= mul_y;
						ex_q[15:12] <= ex_q[15:12] - 4'd1;
						state_q <= S_PCHK;
					end
				end
				S_CRD: begin
					state_q <= S_CGO;
				end
				S_CGO: begin
					state_q <= S_CWAIT;
				end
				S_CWAIT: begin
					if (mul_stat.done) begin
						acc_q[j_q] <= sat_add(acc_q[j_q], mul_y);
						j_q <= j_q + 2'd1;
						state_q <= (j_q == 2'd3) ? S_NXT : S_CRD;
					end
				end
				S_NXT: begin
					if (t_q == last_q) begin
						state_q <= S_FIN1;
					end else begin
						t_q <= t_q + CNT_W'(1);
						state_q <= S_TRD;
					end
				end
				S_FIN1: begin
					for (int i = 0; i < 4; i++) begin
						s48_q[i] <= sat48(acc_q[i]);
					end
					state_q <= S_FIN2;
				end
				S_FIN2: begin
					result.xptar <= s48_q[0];
					result.ytar_cm <= times100(s48_q[1]);
					result.yptar <= s48_q[2];
					result.delta_pct <= times100(s48_q[3]);
					result.status <= 1'b0;
					result_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);

	// an accepted word either strobes at once or keeps the unit busy
	`ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy || result_valid)
	// the multiplier is never restarted while a product is in flight
	`ASSERT_IMPLY(a_mul_free, clk, arst_n, mul_go, !mul_stat.busy)
	// products only come back while the sequencer waits for one
	`ASSERT_IMPLY(a_mul_done, clk, arst_n, mul_stat.done,
		state_q == S_PWAIT || state_q == S_CWAIT || state_q == S_DEND)
endmodule
`default_nettype wire
